// ===== rtl/id_membership_table_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ID_MEMBERSHIP_TABLE_TOP_MACROS_SVH
`define ID_MEMBERSHIP_TABLE_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define IDMT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IDMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/idmt_pkg.sv =====
package idmt_pkg;

    localparam int OPCODE_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

endpackage

// ===== rtl/idmt_req_if.sv =====
interface idmt_req_if #(
    parameter int ID_BITS = 31
);
    logic                         valid;
    logic                         ready;
    logic [idmt_pkg::OPCODE_W-1:0] opcode;
    logic [ID_BITS-1:0]           id;

    modport source (output valid, output opcode, output id, input ready);
    modport sink   (input valid, input opcode, input id, output ready);
endinterface

// ===== rtl/idmt_rsp_if.sv =====
interface idmt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic                         status;
    logic [idmt_pkg::COUNT_W-1:0] held_count;

    modport source (output valid, output found, output status, output held_count,
                    input ready);
    modport sink   (input valid, input found, input status, input held_count,
                    output ready);
endinterface

// ===== rtl/idmt_match.sv =====
// Shared slot comparator: a free slot for add, a live matching slot otherwise.
module idmt_match #(
    parameter int ID_BITS = 31
) (
    input  logic [ID_BITS:0]   word,
    input  logic [ID_BITS-1:0] key,
    input  logic               want_free,
    output logic               hit
);
    logic live;
    logic same;

    assign live = word[ID_BITS];
    assign same = (word[ID_BITS-1:0] == key);
    assign hit  = want_free ? !live : (live && same);
endmodule

// ===== rtl/id_membership_table_top.sv =====
// Multiset table of ENTRIES id slots, one request at a time. Find, add and
// remove scan the slot memory from slot 0 with a single comparator, one slot
// per cycle, and stop at the first hit; a miss (or a full table on add) scans
// every slot. Clear rewrites every slot. After reset a clearing pass over
// every slot runs before the first request is taken. held_count is the live
// count cut to 9 bits.
module id_membership_table_top #(
    parameter int ENTRIES = 256,
    parameter int ID_BITS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    idmt_req_if.sink    req,
    idmt_rsp_if.source  rsp
);
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = ID_BITS + 1;

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_WIPE = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [2:0]                    state_reg, state_next;
    logic [idmt_pkg::OPCODE_W-1:0] op_reg, op_next;
    logic [ID_BITS-1:0]            key_reg, key_next;
    logic [IDX_W-1:0]              addr_reg, addr_next;
    logic                          issue_done_reg, issue_done_next;
    logic                          chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]              chk_addr_reg, chk_addr_next;
    logic [CNT_W-1:0]              live_count_reg, live_count_next;
    logic                          found_reg, found_next;
    logic                          status_reg, status_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_found_reg, out_found_next;
    logic                          out_status_reg, out_status_next;
    logic [idmt_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [WORD_W-1:0]             rd_word_reg;

    logic [WORD_W-1:0] mem [ENTRIES];

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              hit;
    logic              addr_last;
    logic              chk_last;
    logic              out_free;

    idmt_match #(.ID_BITS(ID_BITS)) u_match (
        .word      (rd_word_reg),
        .key       (key_reg),
        .want_free (op_reg == idmt_pkg::OP_ADD),
        .hit       (hit)
    );

    assign addr_last = (addr_reg == LAST_IDX);
    assign chk_last  = (chk_addr_reg == LAST_IDX);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.held_count = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        chk_valid_next  = chk_valid_reg;
        chk_addr_next   = chk_addr_reg;
        live_count_next = live_count_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        we              = 1'b0;
        waddr           = addr_reg;
        wdata           = '0;

        unique case (state_reg)
            ST_INIT, ST_WIPE:
            begin
                we        = 1'b1;
                addr_next = addr_last ? '0 : addr_reg + 1'b1;
                if (addr_last)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_RESP;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.opcode;
                    key_next        = req.id;
                    addr_next       = '0;
                    issue_done_next = 1'b0;
                    chk_valid_next  = 1'b0;
                    found_next      = 1'b0;
                    status_next     = 1'b0;
                    if (req.opcode == idmt_pkg::OP_CLEAR)
                    begin
                        live_count_next = '0;
                        state_next      = ST_WIPE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // one read issued per cycle, compared in the cycle after
                chk_valid_next = !issue_done_reg;
                chk_addr_next  = addr_reg;
                if (!issue_done_reg)
                begin
                    addr_next       = addr_last ? '0 : addr_reg + 1'b1;
                    issue_done_next = addr_last;
                end
                if (chk_valid_reg && hit)
                begin
                    state_next = ST_RESP;
                    waddr      = chk_addr_reg;
                    unique case (op_reg)
                        idmt_pkg::OP_ADD:
                        begin
                            we              = 1'b1;
                            wdata           = {1'b1, key_reg};
                            live_count_next = live_count_reg + 1'b1;
                        end
                        idmt_pkg::OP_REMOVE:
                        begin
                            we              = 1'b1;
                            wdata           = {1'b0, key_reg};
                            found_next      = 1'b1;
                            live_count_next = live_count_reg - 1'b1;
                        end
                        default:
                        begin
                            found_next = 1'b1;
                        end
                    endcase
                end
                else if (chk_valid_reg && chk_last)
                begin
                    state_next  = ST_RESP;
                    status_next = (op_reg == idmt_pkg::OP_ADD);
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_status_next = status_reg;
                    out_count_next  = idmt_pkg::COUNT_W'(live_count_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
                addr_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            live_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            issue_done_reg <= issue_done_next;
            chk_valid_reg  <= chk_valid_next;
            live_count_reg <= live_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        chk_addr_reg   <= chk_addr_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // slot memory: bit ID_BITS is the live flag
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_word_reg <= mem[addr_reg];
    end
endmodule

// ===== rtl/idmt_checker.sv =====
`include "id_membership_table_top_macros.svh"

module idmt_checker #(
    parameter int ENTRIES = 256
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic [idmt_pkg::OPCODE_W-1:0] req_opcode,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic                         rsp_found,
    input logic                         rsp_status,
    input logic [idmt_pkg::COUNT_W-1:0] rsp_held_count
);
    localparam logic [idmt_pkg::COUNT_W-1:0] FULL_COUNT = idmt_pkg::COUNT_W'(ENTRIES);

    // one request in flight: ready drops right after a request is taken
    `IDMT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")

    // a refused add only happens on a full table
    `IDMT_ASSERT(a_full_status, clk, rst_n, (rsp_valid && rsp_status) |-> (rsp_held_count == FULL_COUNT), "full status with free slots")

    // refused add never reports a hit
    `IDMT_ASSERT(a_status_found, clk, rst_n, rsp_valid |-> !(rsp_found && rsp_status), "found and status both set")

    // stalled response holds
    `IDMT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_held_count) && $stable(rsp_found), "stalled response changed")

    // the response to a clear shows up as ready returns and reports zero
    `IDMT_ASSERT_NEXT(a_clear_zero, clk, rst_n, req_valid && req_ready && (req_opcode == idmt_pkg::OP_CLEAR), req_ready[->1] ##0 (rsp_valid && rsp_held_count == '0), "clear left a nonzero count")
endmodule

bind id_membership_table_top idmt_checker #(.ENTRIES(ENTRIES)) u_idmt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_opcode     (req.opcode),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.found),
    .rsp_status     (rsp.status),
    .rsp_held_count (rsp.held_count)
);
